[sv/lge_pkg.sv]
package lge_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RESP,
    ST_GEN
  } state_e;

  localparam logic [1:0] MODE_TOGGLE = 2'd0;
  localparam logic [1:0] MODE_STEP   = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

[sv/lge_col_cell.sv]
module lge_col_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lge_pkg::cell_ctl_t ctl_i,
  input  logic             bit_i,
  input  logic [1:0]       left_sum_i,
  input  logic [1:0]       right_sum_i,
  output logic [1:0]       sum_o,
  output logic             next_o
);

  logic up_q, mid_q, dn_q;
  logic [3:0] count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q  <= 1'b0;
      mid_q <= 1'b0;
      dn_q  <= 1'b0;
    end else if (ctl_i.clear) begin
      up_q  <= 1'b0;
      mid_q <= 1'b0;
      dn_q  <= 1'b0;
    end else if (ctl_i.shift) begin
      up_q  <= mid_q;
      mid_q <= dn_q;
      dn_q  <= bit_i;
    end
  end

  assign sum_o = {1'b0, up_q} + {1'b0, mid_q} + {1'b0, dn_q};

  assign count = {2'b00, left_sum_i} + {2'b00, right_sum_i}
               + {3'b000, up_q} + {3'b000, dn_q};

  always_comb begin
    if (mid_q) begin
      next_o = (count == lge_pkg::SURVIVE_COUNT) || (count == lge_pkg::BIRTH_COUNT);
    end else begin
      next_o = (count == lge_pkg::BIRTH_COUNT);
    end
  end

endmodule

[sv/lge_cell_row.sv]
module lge_cell_row #(
  parameter int GRID_COLS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lge_pkg::cell_ctl_t   ctl_i,
  input  logic [GRID_COLS-1:0] row_i,
  output logic [GRID_COLS-1:0] next_row_o
);

  logic [1:0] vsum [GRID_COLS];

  for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
    logic [1:0] left_sum;
    logic [1:0] right_sum;

    if (c == 0) begin : g_left_edge
      assign left_sum = 2'd0;
    end else begin : g_left
      assign left_sum = vsum[c-1];
    end

    if (c == GRID_COLS - 1) begin : g_right_edge
      assign right_sum = 2'd0;
    end else begin : g_right
      assign right_sum = vsum[c+1];
    end

    lge_col_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl_i),
      .bit_i       (row_i[c]),
      .left_sum_i  (left_sum),
      .right_sum_i (right_sum),
      .sum_o       (vsum[c]),
      .next_o      (next_row_o[c])
    );
  end

endmodule

[sv/lge_grid_mem.sv]
module lge_grid_mem #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64,
  localparam int RW = $clog2(GRID_ROWS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lge_pkg::mem_ctl_t    ctl_i,
  input  logic [RW-1:0]        rd_addr_i,
  input  logic [RW-1:0]        wr_addr_i,
  input  logic [GRID_COLS-1:0] wr_data_i,
  output logic [GRID_COLS-1:0] rd_data_o
);

  logic [GRID_COLS-1:0] mem [GRID_ROWS];
  logic [GRID_ROWS-1:0] row_valid_q;
  logic [GRID_COLS-1:0] rd_data_q;
  logic                 rd_live_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_live_q   <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      rd_live_q <= ctl_i.rd_en & row_valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_live_q ? rd_data_q : '0;

endmodule

[sv/life_grid_generation_engine_top.sv]
// Life engine on a GRID_ROWS by GRID_COLS grid under rule B3/S23, all cells dead after reset
// and no wraparound at the edges. An item is taken when start_i is high and busy_o is low; its
// result appears on cell_alive_o for the one cycle that done_o is high. done_o is registered
// from the response state, which a toggle or a read reaches through the read state and a step
// through the generation sweep and then the read state. The receiver cannot hold a result off,
// so it must capture cell_alive_o in that one cycle.
// A generation reads one grid row per cycle from the row memory into a row of column cells
// that hold a three-row window, and writes each new row back once the row below it is in the
// window, so the single row read port sets the sweep length. A new item may be started in the
// same cycle that done_o is high. Per-row valid bits make the grid read as dead after reset,
// with no clearing pass.
module life_grid_generation_engine_top #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] mode_i,
  input  logic [5:0] col_i,
  input  logic [5:0] row_i,
  output logic       busy_o,
  output logic       done_o,
  output logic       cell_alive_o
);

  localparam int RW = $clog2(GRID_ROWS);
  localparam int CW = $clog2(GRID_COLS);
  localparam int KW = $clog2(GRID_ROWS + 3);

  lge_pkg::state_e state_q, state_d;
  logic [KW-1:0]   k_q, k_d;
  logic [1:0]      mode_q;
  logic [CW-1:0]   col_q;
  logic [RW-1:0]   row_q;
  logic            inside_q;
  logic            done_q, done_d;
  logic            alive_q, alive_d;

  lge_pkg::mem_ctl_t    mem_ctl;
  lge_pkg::cell_ctl_t   cell_ctl;
  logic [RW-1:0]        rd_addr;
  logic [RW-1:0]        wr_addr;
  logic [GRID_COLS-1:0] wr_data;
  logic [GRID_COLS-1:0] rd_data;
  logic [GRID_COLS-1:0] next_row;
  logic [GRID_COLS-1:0] toggle_mask;
  logic                 accept;
  logic                 cur_bit;

  assign accept      = start_i & ~busy_o;
  assign busy_o      = (state_q != lge_pkg::ST_IDLE);
  assign toggle_mask = {{(GRID_COLS-1){1'b0}}, 1'b1} << col_q;
  assign cur_bit     = rd_data[col_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lge_pkg::ST_IDLE;
      k_q     <= '0;
      done_q  <= 1'b0;
      alive_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      done_q  <= done_d;
      alive_q <= alive_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_i;
      col_q    <= CW'(col_i);
      row_q    <= RW'(row_i);
      inside_q <= (32'(col_i) < GRID_COLS) && (32'(row_i) < GRID_ROWS);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lge_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (mode_i == lge_pkg::MODE_STEP) ? lge_pkg::ST_GEN : lge_pkg::ST_READ;
        end
      end
      lge_pkg::ST_READ: state_d = lge_pkg::ST_RESP;
      lge_pkg::ST_RESP: state_d = lge_pkg::ST_IDLE;
      lge_pkg::ST_GEN: begin
        if (k_q == KW'(GRID_ROWS + 2)) begin
          state_d = lge_pkg::ST_READ;
        end
      end
      default: state_d = lge_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl  = '0;
    cell_ctl = '0;
    rd_addr  = row_q;
    wr_addr  = row_q;
    wr_data  = rd_data ^ toggle_mask;
    k_d      = '0;
    done_d   = 1'b0;
    alive_d  = 1'b0;
    unique case (state_q)
      lge_pkg::ST_IDLE: begin
      end
      lge_pkg::ST_READ: begin
        mem_ctl.rd_en = 1'b1;
      end
      lge_pkg::ST_RESP: begin
        done_d = 1'b1;
        if (inside_q) begin
          if (mode_q == lge_pkg::MODE_TOGGLE) begin
            mem_ctl.wr_en = 1'b1;
            alive_d       = ~cur_bit;
          end else begin
            alive_d = cur_bit;
          end
        end
      end
      lge_pkg::ST_GEN: begin
        k_d            = k_q + KW'(1);
        mem_ctl.rd_en  = (k_q < KW'(GRID_ROWS));
        rd_addr        = RW'(k_q);
        cell_ctl.clear = (k_q == '0);
        cell_ctl.shift = (k_q != '0) && (k_q <= KW'(GRID_ROWS + 1));
        mem_ctl.wr_en  = (k_q >= KW'(3));
        wr_addr        = RW'(k_q - KW'(3));
        wr_data        = next_row;
      end
      default: begin
      end
    endcase
  end

  lge_grid_mem #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  lge_cell_row #(
    .GRID_COLS (GRID_COLS)
  ) u_cells (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (cell_ctl),
    .row_i      (rd_data),
    .next_row_o (next_row)
  );

  assign done_o       = done_q;
  assign cell_alive_o = alive_q;

`ifndef SYNTHESIS
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("Block not busy after an accepted transfer.");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Result strobe held for more than one cycle.");

  a_outside_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !inside_q |-> !cell_alive_o)
    else $error("Live result for a coordinate outside the grid.");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lge_pkg::ST_IDLE |-> !mem_ctl.wr_en)
    else $error("Grid memory written while idle.");

  a_sweep_addr_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.wr_en && mem_ctl.rd_en |-> wr_addr != rd_addr)
    else $error("Generation sweep reads and writes the same row.");
`endif

endmodule

[sim/tb_life_grid_generation_engine_top.sv]
module tb_life_grid_generation_engine_top;

  localparam int TB_COLS = 64;
  localparam int TB_ROWS = 64;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] col;
    logic [5:0] row;
  } life_cmd_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic [1:0] mode_i = lge_pkg::MODE_READ;
  logic [5:0] col_i = '0;
  logic [5:0] row_i = '0;
  logic       busy_o;
  logic       done_o;
  logic       cell_alive_o;

  life_cmd_t cmd_queue[$];
  bit        alive_queue[$];
  bit        life_cells[TB_ROWS][TB_COLS];
  int        mismatch_count = 0;
  int        idle_left = 0;
  bit        no_idle = 1'b0;

  life_grid_generation_engine_top #(
    .GRID_COLS(TB_COLS),
    .GRID_ROWS(TB_ROWS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .mode_i      (mode_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .cell_alive_o(cell_alive_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit life_apply(input logic [1:0] m, input logic [5:0] c,
                                    input logic [5:0] r);
    bit snap[TB_ROWS][TB_COLS];
    int n;
    int nr;
    int nc;
    bit on_grid;
    on_grid = (c < TB_COLS) && (r < TB_ROWS);
    if (m == lge_pkg::MODE_TOGGLE) begin
      if (on_grid) life_cells[r][c] = !life_cells[r][c];
    end else if (m == lge_pkg::MODE_STEP) begin
      snap = life_cells;
      for (int y = 0; y < TB_ROWS; y++) begin
        for (int x = 0; x < TB_COLS; x++) begin
          n = 0;
          for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
              nr = y + dy;
              nc = x + dx;
              if ((dy != 0 || dx != 0) && nr >= 0 && nr < TB_ROWS && nc >= 0 && nc < TB_COLS)
                n += snap[nr][nc];
            end
          end
          if (snap[y][x])
            life_cells[y][x] = (n == lge_pkg::SURVIVE_COUNT) || (n == lge_pkg::BIRTH_COUNT);
          else life_cells[y][x] = (n == lge_pkg::BIRTH_COUNT);
        end
      end
    end
    return on_grid ? life_cells[r][c] : 1'b0;
  endfunction

  task automatic push_cmd(input logic [1:0] m, input int c, input int r);
    life_cmd_t item;
    item.mode = m;
    item.col = c[5:0];
    item.row = r[5:0];
    cmd_queue.push_back(item);
  endtask

  // Driver: one transfer per accepted item, with a random idle gap drawn after each.
  always @(posedge clk_i or negedge rst_ni) begin
    life_cmd_t nxt;
    int gap;
    if (!rst_ni) begin
      start_i <= 1'b0;
      idle_left <= 0;
    end else if (start_i && !busy_o) begin
      alive_queue.push_back(life_apply(mode_i, col_i, row_i));
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap == 0 && cmd_queue.size() != 0) begin
        nxt = cmd_queue.pop_front();
        mode_i <= nxt.mode;
        col_i <= nxt.col;
        row_i <= nxt.row;
      end else begin
        start_i <= 1'b0;
        idle_left <= gap;
      end
    end else if (!start_i) begin
      if (idle_left != 0) begin
        idle_left <= idle_left - 1;
      end else if (cmd_queue.size() != 0) begin
        nxt = cmd_queue.pop_front();
        mode_i <= nxt.mode;
        col_i <= nxt.col;
        row_i <= nxt.row;
        start_i <= 1'b1;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    bit want;
    if (rst_ni && done_o) begin
      if (alive_queue.size() == 0) begin
        $error("cell_alive: unexpected result, actual %0b", cell_alive_o);
        mismatch_count++;
      end else begin
        want = alive_queue.pop_front();
        if (cell_alive_o !== want) begin
          $error("cell_alive: expected %0b, actual %0b", want, cell_alive_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int total;
    int r0;
    int c0;
    int ntog;
    int nstep;
    for (int y = 0; y < TB_ROWS; y++)
      for (int x = 0; x < TB_COLS; x++) life_cells[y][x] = 1'b0;

    push_cmd(lge_pkg::MODE_READ, 0, 0);
    push_cmd(lge_pkg::MODE_READ, 63, 63);
    push_cmd(lge_pkg::MODE_TOGGLE, 0, 0);
    push_cmd(lge_pkg::MODE_TOGGLE, 1, 0);
    push_cmd(lge_pkg::MODE_TOGGLE, 2, 0);
    push_cmd(lge_pkg::MODE_TOGGLE, 63, 63);
    push_cmd(lge_pkg::MODE_TOGGLE, 62, 63);
    push_cmd(lge_pkg::MODE_TOGGLE, 63, 62);
    push_cmd(lge_pkg::MODE_TOGGLE, 0, 63);
    push_cmd(lge_pkg::MODE_TOGGLE, 0, 63);
    push_cmd(MODE_SPARE, 0, 63);
    push_cmd(lge_pkg::MODE_STEP, 1, 1);
    push_cmd(lge_pkg::MODE_READ, 62, 62);
    push_cmd(lge_pkg::MODE_READ, 1, 0);
    push_cmd(MODE_SPARE, 63, 63);
    push_cmd(lge_pkg::MODE_STEP, 0, 0);
    push_cmd(lge_pkg::MODE_READ, 2, 0);
    push_cmd(lge_pkg::MODE_TOGGLE, 42, 21);
    push_cmd(lge_pkg::MODE_READ, 42, 21);
    push_cmd(lge_pkg::MODE_STEP, 42, 21);
    push_cmd(MODE_SPARE, 21, 42);

    // Each episode seeds a dense window, often at an edge or corner, then evolves it.
    total = cmd_queue.size();
    while (total < 2000) begin
      case ($urandom_range(0, 3))
        0: r0 = 0;
        1: r0 = TB_ROWS - 8;
        default: r0 = $urandom_range(0, TB_ROWS - 8);
      endcase
      case ($urandom_range(0, 3))
        0: c0 = 0;
        1: c0 = TB_COLS - 8;
        default: c0 = $urandom_range(0, TB_COLS - 8);
      endcase
      ntog = $urandom_range(12, 30);
      for (int i = 0; i < ntog; i++) begin
        if ($urandom_range(0, 9) == 0)
          push_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63));
        else
          push_cmd(lge_pkg::MODE_TOGGLE, c0 + $urandom_range(0, 7), r0 + $urandom_range(0, 7));
      end
      nstep = $urandom_range(1, 6);
      for (int s = 0; s < nstep; s++) begin
        push_cmd(lge_pkg::MODE_STEP, c0 + $urandom_range(0, 7), r0 + $urandom_range(0, 7));
        for (int k = $urandom_range(2, 5); k > 0; k--)
          push_cmd($urandom_range(0, 1) ? lge_pkg::MODE_READ : MODE_SPARE,
                   c0 + $urandom_range(0, 9) - 1, r0 + $urandom_range(0, 9) - 1);
      end
      total = cmd_queue.size();
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(negedge clk_i);
    while (cmd_queue.size() != 0 || start_i || alive_queue.size() != 0);
    repeat (100) @(negedge clk_i);

    if (mismatch_count == 0 && alive_queue.size() == 0) begin
      $display("tb_life_grid_generation_engine_top: done, clean");
    end else begin
      $display("tb_life_grid_generation_engine_top: done, errors");
    end
    $finish;
  end

  initial begin
    #(8 * 2000000);
    $display("tb_life_grid_generation_engine_top: done, errors");
    $finish;
  end

endmodule

[files.f]
sv/lge_pkg.sv
sv/lge_col_cell.sv
sv/lge_cell_row.sv
sv/lge_grid_mem.sv
sv/life_grid_generation_engine_top.sv
sim/tb_life_grid_generation_engine_top.sv
